// ===== src/assert_macros.svh =====
// assertion macros shared by the sweep animator rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/lssa_pkg.sv =====
// shared types, widths and register indexes for the sweep animator
// no dependencies; imported by every module and interface of the block
`timescale 1ns / 1ps

package lssa_pkg;

   localparam int CoordWidth    = 16;
   localparam int ColorWidth    = 24;
   localparam int StampWidth    = 32;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 24;
   localparam int FactorWidth   = CoordWidth + 1;
   localparam int ProductWidth  = 2 * CoordWidth + 1;
   localparam int SumWidth      = StampWidth + 1;
   localparam int DivSteps      = CoordWidth;
   localparam int DivCountWidth = $clog2(DivSteps);

   localparam logic [CsrIndexWidth-1:0] CSR_START_PIXEL  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_END_PIXEL    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_CARET_LENGTH = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_PERIOD_MS    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_SWEEP_COLOR  = 3'd4;

   localparam logic [CoordWidth-1:0] START_PIXEL_RESET  = 16'd0;
   localparam logic [CoordWidth-1:0] END_PIXEL_RESET    = 16'd15;
   localparam logic [CoordWidth-1:0] CARET_LENGTH_RESET = 16'd4;
   localparam logic [CoordWidth-1:0] PERIOD_MS_RESET    = 16'd500;
   localparam logic [ColorWidth-1:0] SWEEP_COLOR_RESET  = 24'hFFA500;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV,
      ST_FIN,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load_item;
      logic exec_tick;
      logic load_product;
      logic div_start;
      logic update_head;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic is_query;
      logic tick_active;
      logic div_done;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== src/lssa_req_if.sv =====
// request channel of the sweep animator: valid, ready and item fields
// depends on lssa_pkg
`timescale 1ns / 1ps

interface lssa_req_if
   import lssa_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [StampWidth-1:0] now_ms;
   logic                  signal_on;
   logic [CoordWidth-1:0] pixel_index;
   logic [ColorWidth-1:0] background_color;

   modport source (
      output valid, cmd, now_ms, signal_on, pixel_index, background_color,
      input  ready
   );

   modport sink (
      input  valid, cmd, now_ms, signal_on, pixel_index, background_color,
      output ready
   );
endinterface

// ===== src/lssa_rsp_if.sv =====
// response channel of the sweep animator: valid, ready and result fields
// depends on lssa_pkg
`timescale 1ns / 1ps

interface lssa_rsp_if
   import lssa_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [ColorWidth-1:0] pixel_color;
   logic                  needs_background;
   logic                  position_changed;
   logic                  active;
   logic [CoordWidth-1:0] caret_position;

   modport source (
      output valid, pixel_color, needs_background, position_changed, active,
             caret_position,
      input  ready
   );

   modport sink (
      input  valid, pixel_color, needs_background, position_changed, active,
             caret_position,
      output ready
   );
endinterface

// ===== src/lssa_div.sv =====
// iterative restoring divider, one quotient bit per cycle, saturating at 16 bits
// depends on lssa_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lssa_div
   import lssa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [ProductWidth-1:0] numerator,
   input  logic [CoordWidth-1:0]   divisor,
   output logic                    done,
   output logic [CoordWidth-1:0]   quotient
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DivCountWidth-1:0] count_ff, count_in;
   logic [CoordWidth-1:0]    rem_ff, rem_in;
   logic [CoordWidth-1:0]    quo_ff, quo_in;
   logic [CoordWidth:0]      trial;
   logic                     trial_fits;
   logic                     saturate;

   assign trial      = {rem_ff, quo_ff[CoordWidth-1]};
   assign trial_fits = trial >= {1'b0, divisor};
   assign saturate   = numerator[ProductWidth-1:CoordWidth] >= {1'b0, divisor};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         count_in = '0;
         if (divisor == '0) begin
            quo_in  = '0;
            done_in = 1'b1;
         end else if (saturate) begin
            quo_in  = '1;
            done_in = 1'b1;
         end else begin
            rem_in  = numerator[2*CoordWidth-1:CoordWidth];
            quo_in  = numerator[CoordWidth-1:0];
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in   = trial_fits ? CoordWidth'(trial - {1'b0, divisor}) : trial[CoordWidth-1:0];
         quo_in   = {quo_ff[CoordWidth-2:0], trial_fits};
         count_in = count_ff + 1'b1;
         if (count_ff == DivCountWidth'(DivSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `ASSERT_NEXT(a_div_start_progress, clock, reset, start, busy_ff || done_ff)

endmodule

// ===== src/lssa_dpath.sv =====
// datapath: config registers, sweep state, tick arithmetic, pixel test, response register
// depends on lssa_pkg, lssa_req_if, lssa_rsp_if, lssa_div and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lssa_dpath
   import lssa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   lssa_req_if.sink                 req_chan,
   lssa_rsp_if.source               rsp_chan,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  dp_cmd_type               cmd,
   output dp_status_type            status
);

   // configuration
   logic [CoordWidth-1:0] start_pixel_ff, start_pixel_in;
   logic [CoordWidth-1:0] end_pixel_ff, end_pixel_in;
   logic [CoordWidth-1:0] caret_length_ff, caret_length_in;
   logic [CoordWidth-1:0] period_ms_ff, period_ms_in;
   logic [ColorWidth-1:0] sweep_color_ff, sweep_color_in;

   // sweep state
   logic [StampWidth-1:0] last_tick_ff, last_tick_in;
   logic [CoordWidth-1:0] time_ff, time_in;
   logic [CoordWidth-1:0] head_ff, head_in;
   logic                  changed_ff, changed_in;

   // held request
   logic                  cmd_ff;
   logic                  on_ff;
   logic [CoordWidth-1:0] pix_ff;
   logic [ColorWidth-1:0] bg_ff;
   logic [StampWidth-1:0] delta_ff;

   // arithmetic
   logic [FactorWidth-1:0]  factor_ff;
   logic [ProductWidth-1:0] product_ff;
   logic [SumWidth-1:0]     sum;
   logic [SumWidth-1:0]     wrapped;
   logic [CoordWidth-1:0]   next_time;
   logic [CoordWidth-1:0]   span_less_one;
   logic                    div_done;
   logic [CoordWidth-1:0]   quotient;

   // pixel test
   logic [CoordWidth-1:0] local_idx;
   logic [CoordWidth-1:0] window_lo;
   logic                  lit;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ColorWidth-1:0] rsp_color_ff;
   logic                  rsp_need_bg_ff;
   logic                  rsp_changed_ff;
   logic                  rsp_active_ff;
   logic [CoordWidth-1:0] rsp_position_ff;

   always_comb begin
      start_pixel_in  = start_pixel_ff;
      end_pixel_in    = end_pixel_ff;
      caret_length_in = caret_length_ff;
      period_ms_in    = period_ms_ff;
      sweep_color_in  = sweep_color_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_PIXEL:  start_pixel_in  = csr_wdata[CoordWidth-1:0];
            CSR_END_PIXEL:    end_pixel_in    = csr_wdata[CoordWidth-1:0];
            CSR_CARET_LENGTH: caret_length_in = csr_wdata[CoordWidth-1:0];
            CSR_PERIOD_MS:    period_ms_in    = csr_wdata[CoordWidth-1:0];
            CSR_SWEEP_COLOR:  sweep_color_in  = csr_wdata[ColorWidth-1:0];
            default: ;
         endcase
      end
   end

   // tick time update
   assign sum     = SumWidth'(time_ff) + SumWidth'(delta_ff);
   assign wrapped = sum - SumWidth'(period_ms_ff);

   always_comb begin
      if (sum > SumWidth'(period_ms_ff)) begin
         if (!on_ff) begin
            next_time = '0;
         end else if (wrapped > SumWidth'(period_ms_ff)) begin
            next_time = period_ms_ff;
         end else begin
            next_time = wrapped[CoordWidth-1:0];
         end
      end else begin
         next_time = sum[CoordWidth-1:0];
      end
   end

   assign span_less_one = (start_pixel_ff < end_pixel_ff) ? end_pixel_ff - start_pixel_ff
                                                          : start_pixel_ff - end_pixel_ff;

   always_comb begin
      last_tick_in = last_tick_ff;
      time_in      = time_ff;
      head_in      = head_ff;
      changed_in   = changed_ff;
      if (cmd.load_item) begin
         changed_in = 1'b0;
         if (req_chan.cmd == CMD_TICK) begin
            last_tick_in = req_chan.now_ms;
         end
      end
      if (cmd.exec_tick && status.tick_active) begin
         time_in = next_time;
      end
      if (cmd.update_head && (quotient != head_ff)) begin
         head_in    = quotient;
         changed_in = 1'b1;
      end
   end

   lssa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .numerator (product_ff),
      .divisor   (period_ms_ff),
      .done      (div_done),
      .quotient  (quotient)
   );

   // caret window test, local index folds both directions into the distance of the pixel from start
   assign local_idx = (start_pixel_ff < end_pixel_ff) ? pix_ff - start_pixel_ff
                                                      : start_pixel_ff - pix_ff;
   assign window_lo = (head_ff > caret_length_ff) ? head_ff - caret_length_ff : '0;
   assign lit       = (window_lo <= local_idx) && (local_idx < head_ff);

   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready ? 1'b1 : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pixel_ff  <= START_PIXEL_RESET;
         end_pixel_ff    <= END_PIXEL_RESET;
         caret_length_ff <= CARET_LENGTH_RESET;
         period_ms_ff    <= PERIOD_MS_RESET;
         sweep_color_ff  <= SWEEP_COLOR_RESET;
         last_tick_ff    <= '0;
         time_ff         <= '0;
         head_ff         <= '0;
         changed_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         start_pixel_ff  <= start_pixel_in;
         end_pixel_ff    <= end_pixel_in;
         caret_length_ff <= caret_length_in;
         period_ms_ff    <= period_ms_in;
         sweep_color_ff  <= sweep_color_in;
         last_tick_ff    <= last_tick_in;
         time_ff         <= time_in;
         head_ff         <= head_in;
         changed_ff      <= changed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         cmd_ff   <= req_chan.cmd;
         on_ff    <= req_chan.signal_on;
         pix_ff   <= req_chan.pixel_index;
         bg_ff    <= req_chan.background_color;
         delta_ff <= req_chan.now_ms - last_tick_ff;
      end
      if (cmd.exec_tick) begin
         factor_ff <= FactorWidth'(span_less_one) + FactorWidth'(1)
                      + FactorWidth'(caret_length_ff);
      end
      if (cmd.load_product) begin
         product_ff <= ProductWidth'(time_ff) * ProductWidth'(factor_ff);
      end
      if (cmd.load_rsp) begin
         rsp_color_ff    <= (cmd_ff == CMD_QUERY) ? (lit ? sweep_color_ff : bg_ff) : '0;
         rsp_need_bg_ff  <= (cmd_ff == CMD_QUERY) && !lit;
         rsp_changed_ff  <= changed_ff;
         rsp_active_ff   <= time_ff != '0;
         rsp_position_ff <= head_ff;
      end
   end

   assign status.is_query    = cmd_ff == CMD_QUERY;
   assign status.tick_active = on_ff || (time_ff != '0);
   assign status.div_done    = div_done;
   assign status.rsp_free    = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.pixel_color      = rsp_color_ff;
   assign rsp_chan.needs_background = rsp_need_bg_ff;
   assign rsp_chan.position_changed = rsp_changed_ff;
   assign rsp_chan.active           = rsp_active_ff;
   assign rsp_chan.caret_position   = rsp_position_ff;

   `ASSERT_NEXT(a_head_only_on_update, clock, reset, !cmd.update_head, $stable(head_ff))
   `ASSERT_IMPLIES(a_load_only_when_free, clock, reset, cmd.load_rsp, status.rsp_free)
   `ASSERT_NEXT(a_time_within_period, clock, reset,
                cmd.exec_tick && on_ff && (sum > SumWidth'(period_ms_ff)),
                time_ff <= period_ms_ff)

endmodule

// ===== src/lssa_ctrl.sv =====
// controller state machine sequencing requests through the datapath
// depends on lssa_pkg
`timescale 1ns / 1ps

module lssa_ctrl
   import lssa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_query) begin
               state_in = ST_DONE;
            end else begin
               cmd.exec_tick = 1'b1;
               state_in      = status.tick_active ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL: begin
            cmd.load_product = 1'b1;
            state_in         = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.update_head = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== src/led_strip_sweep_animator.sv =====
// sweep animator top: a query steps through idle, exec and done, as does a tick when idle;
// while the sweep runs a tick adds one multiply, then up to 16 steps of the bit-serial divider
// one request at a time; a finished response waits in the output register while the
// next request is taken
// synchronous active-high reset loads default config and clears time, head and stamp
// depends on lssa_pkg, lssa_req_if, lssa_rsp_if, lssa_ctrl and lssa_dpath
`timescale 1ns / 1ps

module led_strip_sweep_animator
   import lssa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   lssa_req_if.sink                 req_chan,
   lssa_rsp_if.source               rsp_chan,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_chan.ready = req_ready;

   lssa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lssa_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
